@@ hdl/bfmi_pkg.sv @@
// ----------------------------------------------------------------------------
// bfmi_pkg
// shared types, codes and carry-less arithmetic helpers for the field unit
// ----------------------------------------------------------------------------
`default_nettype none
package bfmi_pkg;

  localparam int unsigned InvCells = 63;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INV_ZERO = 2'd1,
    ST_INV_128  = 2'd2
  } bfmi_status_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_INV = 1'b1
  } bfmi_op_t;

  typedef enum logic [2:0] {
    REG_FIELD_DEGREE = 3'd0
  } bfmi_reg_t;

  // word as it moves down the chain
  typedef struct packed {
    logic         inv;
    logic         deg;
    bfmi_status_t st;
    logic [127:0] r;
    logic [63:0]  x;
  } bfmi_word_t;

  function automatic logic [127:0] clmul64(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] acc;
    acc = '0;
    for (int i = 0; i < 64; i++) begin
      if (b[i]) acc = acc ^ ({64'd0, a} << i);
    end
    return acc;
  endfunction

  // multiply by x^4+x^3+x+1
  function automatic logic [67:0] fold64(input logic [63:0] h);
    return {4'd0, h} ^ {3'd0, h, 1'b0} ^ {1'b0, h, 3'd0} ^ {h, 4'd0};
  endfunction

  function automatic logic [63:0] reduce64(input logic [127:0] p);
    logic [67:0] t;
    logic [67:0] t2;
    t  = fold64(p[127:64]);
    t2 = fold64({60'd0, t[67:64]});
    return p[63:0] ^ t[63:0] ^ t2[63:0];
  endfunction

  // multiply by x^7+x^2+x+1
  function automatic logic [134:0] fold128(input logic [127:0] h);
    return {7'd0, h} ^ {6'd0, h, 1'b0} ^ {5'd0, h, 2'd0} ^ {h, 7'd0};
  endfunction

  function automatic logic [127:0] reduce128(input logic [255:0] w);
    logic [134:0] f;
    logic [134:0] g;
    f = fold128(w[255:128]);
    g = fold128({121'd0, f[134:128]});
    return w[127:0] ^ f[127:0] ^ g[127:0];
  endfunction

  // squaring is linear: spread bits, then reduce
  function automatic logic [63:0] sq64(input logic [63:0] a);
    logic [127:0] s;
    s = '0;
    for (int i = 0; i < 64; i++) begin
      s[2*i] = a[i];
    end
    return reduce64(s);
  endfunction

endpackage
`default_nettype wire

@@ hdl/bfmi_if.sv @@
// ----------------------------------------------------------------------------
// bfmi_in_if / bfmi_out_if
// valid/ready channels carrying operand and result words
// ----------------------------------------------------------------------------
`default_nettype none
interface bfmi_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [63:0] a_low;
  logic [63:0] a_high;
  logic [63:0] b_low;
  logic [63:0] b_high;
  modport source (output valid, operation, a_low, a_high, b_low, b_high, input ready);
  modport sink (input valid, operation, a_low, a_high, b_low, b_high, output ready);
endinterface

interface bfmi_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_low;
  logic [63:0] result_high;
  logic [1:0]  status;
  modport source (output valid, result_low, result_high, status, input ready);
  modport sink (input valid, result_low, result_high, status, output ready);
endinterface
`default_nettype wire

@@ hdl/bfmi_mul.sv @@
// ----------------------------------------------------------------------------
// bfmi_mul
// two-stage multiplier: partial products, then fold-back reduction
// ----------------------------------------------------------------------------
`default_nettype none
module bfmi_mul (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire logic             op,
  input  wire logic             deg,
  input  wire logic [63:0]      al,
  input  wire logic [63:0]      ah,
  input  wire logic [63:0]      bl,
  input  wire logic [63:0]      bh,
  output logic                  out_vld,
  output bfmi_pkg::bfmi_word_t  out_word
);
  import bfmi_pkg::*;

  logic         vld1_r, vld2_r;
  logic         inv1_r, deg1_r;
  bfmi_status_t st1_r, st1_nxt;
  logic [63:0]  x1_r;
  logic [255:0] w1_r, w1_nxt;
  bfmi_word_t   word2_r, word2_nxt;
  logic [127:0] ll, hh, m1, m2;

  always_comb begin
    ll = clmul64(al, bl);
    hh = deg ? clmul64(ah, bh) : '0;
    m1 = deg ? clmul64(al, bh) : '0;
    m2 = deg ? clmul64(ah, bl) : '0;
    w1_nxt = {hh[127:64], hh[63:0] ^ m1[127:64] ^ m2[127:64],
              ll[127:64] ^ m1[63:0] ^ m2[63:0], ll[63:0]};
    if (op != OP_INV) st1_nxt = ST_OK;
    else if (deg) st1_nxt = ST_INV_128;
    else if (al == '0) st1_nxt = ST_INV_ZERO;
    else st1_nxt = ST_OK;
  end

  always_comb begin
    word2_nxt.inv = inv1_r;
    word2_nxt.deg = deg1_r;
    word2_nxt.st  = st1_r;
    word2_nxt.x   = x1_r;
    if (inv1_r) word2_nxt.r = {64'd0, x1_r};
    else if (deg1_r) word2_nxt.r = reduce128(w1_r);
    else word2_nxt.r = {64'd0, reduce64(w1_r[127:0])};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv1_r  <= op;
      deg1_r  <= deg;
      st1_r   <= st1_nxt;
      x1_r    <= al;
      w1_r    <= w1_nxt;
      word2_r <= word2_nxt;
    end
  end

  assign out_vld  = vld2_r;
  assign out_word = word2_r;
endmodule
`default_nettype wire

@@ hdl/bfmi_cell.sv @@
// ----------------------------------------------------------------------------
// bfmi_cell
// one inversion step for an OK inversion word (others pass through): r <- r^2 * x, or r <- r^2 in the last cell
// ----------------------------------------------------------------------------
`default_nettype none
module bfmi_cell #(
  parameter bit LAST = 1'b0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire bfmi_pkg::bfmi_word_t in_word,
  output logic                  out_vld,
  output bfmi_pkg::bfmi_word_t  out_word
);
  import bfmi_pkg::*;

  logic       vld_r;
  bfmi_word_t word_r, word_nxt;
  logic [63:0] s;

  always_comb begin
    word_nxt = in_word;
    s = sq64(in_word.r[63:0]);
    if (in_word.inv && in_word.st == ST_OK) begin
      word_nxt.r = LAST ? {64'd0, s} : {64'd0, reduce64(clmul64(s, in_word.x))};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_word = word_r;
endmodule
`default_nettype wire

@@ hdl/binary_field_mul_inv.sv @@
// pipeline: 2 multiplier stages, then 63 cells;
// the first stage loads at the accepting edge
// throughput: one word per cycle; the whole chain advances together and
// holds while a finished result is not taken
// inversion is a fixed run of 62 square-and-multiply cells plus one square cell
// reset: synchronous active-low rst_n clears all valid bits and field_degree
// ----------------------------------------------------------------------------
// binary_field_mul_inv
// GF(2^64) / GF(2^128) multiplier and GF(2^64) inverter
// ----------------------------------------------------------------------------
`default_nettype none
module binary_field_mul_inv (
  input  wire logic        clk,
  input  wire logic        rst_n,
  bfmi_in_if.sink          in_ch,
  bfmi_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import bfmi_pkg::*;

  logic       deg_r;
  logic       en;
  logic       vld [InvCells+1];
  bfmi_word_t word [InvCells+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_FIELD_DEGREE) begin
      deg_r <= cfg_pwdata[0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_FIELD_DEGREE) ? {31'd0, deg_r} : '0;

  assign en          = !vld[InvCells] || out_ch.ready;
  assign in_ch.ready = en;

  bfmi_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_ch.valid),
    .op       (in_ch.operation),
    .deg      (deg_r),
    .al       (in_ch.a_low),
    .ah       (in_ch.a_high),
    .bl       (in_ch.b_low),
    .bh       (in_ch.b_high),
    .out_vld  (vld[0]),
    .out_word (word[0])
  );

  for (genvar g = 0; g < InvCells; g++) begin : g_cell
    bfmi_cell #(.LAST(g == InvCells - 1)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (vld[g]),
      .in_word  (word[g]),
      .out_vld  (vld[g+1]),
      .out_word (word[g+1])
    );
  end

  // error cases give zero results
  assign out_ch.valid       = vld[InvCells];
  assign out_ch.status      = word[InvCells].st;
  assign out_ch.result_low  = (word[InvCells].st == ST_OK) ? word[InvCells].r[63:0] : '0;
  assign out_ch.result_high = (word[InvCells].st == ST_OK) ? word[InvCells].r[127:64] : '0;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_OK |-> out_ch.result_low == '0 && out_ch.result_high == '0)
    else $error("error word with nonzero result");

  a_no_bad_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.status != 2'd3)
    else $error("undefined status code");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");

  a_small_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !word[InvCells].deg |-> out_ch.result_high == '0)
    else $error("high half set in 64-bit field");
endmodule
`default_nettype wire

@@ test/bfmi_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bfmi_checker
// watches the operand, result and register ports of the field unit, works out
// each result from its own field arithmetic and compares in order
// ----------------------------------------------------------------------------
module bfmi_checker (
  input  logic        clk,
  input  logic        rst_n,
  bfmi_in_if          in_ch,
  bfmi_out_if         out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatches,
  output int          pending
);
  import bfmi_pkg::*;

  typedef struct {
    logic [63:0]  lo;
    logic [63:0]  hi;
    bfmi_status_t st;
  } field_result_t;

  field_result_t result_queue[$];
  logic          wide_field;

  // bit-serial multiply, reducing after every shift
  function automatic logic [127:0] field_mul(logic [127:0] x, logic [127:0] y, logic wide);
    logic [127:0] acc;
    logic         msb;
    int           n;
    acc = '0;
    n = wide ? 128 : 64;
    if (!wide) begin
      x[127:64] = '0;
      y[127:64] = '0;
    end
    for (int i = n - 1; i >= 0; i--) begin
      msb = wide ? acc[127] : acc[63];
      acc = acc << 1;
      if (wide) begin
        if (msb) acc = acc ^ 128'h87;
      end else begin
        acc[127:64] = '0;
        if (msb) acc = acc ^ 128'h1b;
      end
      if (y[i]) acc = acc ^ x;
    end
    return acc;
  endfunction

  function automatic field_result_t predict_result(bfmi_op_t op, logic [127:0] a,
                                                   logic [127:0] b, logic wide);
    field_result_t res;
    logic [127:0]  r;
    res.lo = '0;
    res.hi = '0;
    res.st = ST_OK;
    if (op == OP_MUL) begin
      r = field_mul(a, b, wide);
      res.lo = r[63:0];
      res.hi = r[127:64];
    end else if (wide) begin
      res.st = ST_INV_128;
    end else if (a[63:0] == '0) begin
      res.st = ST_INV_ZERO;
    end else begin
      // a^(2^63-1) by square-and-multiply, then one more square
      r = {64'd0, a[63:0]};
      for (int i = 1; i < 63; i++) r = field_mul(field_mul(r, r, 1'b0), a, 1'b0);
      r = field_mul(r, r, 1'b0);
      res.lo = r[63:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    field_result_t want;
    if (!rst_n) begin
      wide_field = 1'b0;
      result_queue.delete();
      mismatches = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == 3'(4 * REG_FIELD_DEGREE))
        wide_field = cfg_pwdata[0];
      if (in_ch.valid && in_ch.ready)
        result_queue.push_back(predict_result(bfmi_op_t'(in_ch.operation),
                                              {in_ch.a_high, in_ch.a_low},
                                              {in_ch.b_high, in_ch.b_low}, wide_field));
      if (out_ch.valid && out_ch.ready) begin
        if (result_queue.size() == 0) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          want = result_queue.pop_front();
          if (out_ch.result_low !== want.lo) begin
            $error("result_low expected %h got %h", want.lo, out_ch.result_low);
            mismatches++;
          end
          if (out_ch.result_high !== want.hi) begin
            $error("result_high expected %h got %h", want.hi, out_ch.result_high);
            mismatches++;
          end
          if (out_ch.status !== want.st) begin
            $error("status expected %0d got %0d", want.st, out_ch.status);
            mismatches++;
          end
        end
      end
    end
    pending = result_queue.size();
  end
endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives multiply and invert words through both field sizes with bursty
// input and a stalling receiver; the checker judges every result
// ----------------------------------------------------------------------------
module testbench;
  import bfmi_pkg::*;

  localparam int Latency  = 64;
  localparam int Watchdog = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          mismatches;
  int          pending;
  int          idle_cycles = 0;
  int          burst_left = 0;
  logic        long_hold = 1'b0;

  bfmi_in_if  in_ch ();
  bfmi_out_if out_ch ();

  binary_field_mul_inv dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  bfmi_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_MUL;
    in_ch.a_low = '0;
    in_ch.a_high = '0;
    in_ch.b_low = '0;
    in_ch.b_high = '0;
    out_ch.ready = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= Watchdog) begin
      $display("testbench failed");
      $finish;
    end
  end

  // receiver: random stalls, clean stretches, and long hold-offs on request
  initial begin
    int mode_len;
    int mode;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
        long_hold = 1'b0;
      end
      mode = $urandom_range(0, 3);
      mode_len = $urandom_range(1, 40);
      repeat (mode_len) begin
        @(negedge clk);
        case (mode)
          0: begin
            out_ch.ready <= 1'b1;
          end
          1: begin
            out_ch.ready <= ($urandom_range(0, 3) != 0);
          end
          2: begin
            out_ch.ready <= ($urandom_range(0, 1) != 0);
          end
          default: begin
            out_ch.ready <= ($urandom_range(0, 4) == 0);
          end
        endcase
      end
    end
  end

  function automatic logic [63:0] pick_half();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      3: return 64'd1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_word(bfmi_op_t op, logic [63:0] al, logic [63:0] ah,
                           logic [63:0] bl, logic [63:0] bh);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.a_low <= al;
    in_ch.a_high <= ah;
    in_ch.b_low <= bl;
    in_ch.b_high <= bh;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (Latency + 5) @(negedge clk);
  endtask

  task automatic write_degree(logic wide);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(4 * REG_FIELD_DEGREE);
    cfg_pwdata <= {31'd0, wide};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic directed_words();
    send_word(OP_MUL, '0, '0, '0, '0);
    send_word(OP_MUL, '1, '1, '1, '1);
    send_word(OP_MUL, 64'd1, '1, {$urandom, $urandom}, '1);
    send_word(OP_MUL, {$urandom, $urandom}, 64'd1 << 63, 64'd1 << 63, 64'd1);
    send_word(OP_MUL, '1, '0, 64'd1 << 63, '0);
    send_word(OP_INV, '0, '0, '1, '1);
    send_word(OP_INV, '0, '1, '0, '0);
    send_word(OP_INV, 64'd1, '0, '0, '0);
    send_word(OP_INV, '1, '1, '1, '1);
    send_word(OP_INV, 64'd2, '0, {$urandom, $urandom}, '1);
    send_word(OP_INV, {$urandom, $urandom}, {$urandom, $urandom}, '0, '0);
  endtask

  task automatic random_words(int count, logic hold_midway);
    for (int i = 0; i < count; i++) begin
      if (hold_midway && i == count / 2) long_hold = 1'b1;
      send_word(bfmi_op_t'($urandom_range(0, 1)), pick_half(), pick_half(),
                pick_half(), pick_half());
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_degree(1'b0);
    directed_words();
    random_words(200, 1'b1);
    drain();

    write_degree(1'b1);
    directed_words();
    random_words(200, 1'b1);
    drain();

    write_degree(1'b0);
    random_words(80, 1'b0);
    drain();

    if (mismatches == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
